>>> rtl/core/lpgd_pkg.sv
// Shared types and constants for the decimated line point generator.
// Used by every module of the block except lpgd_queue; depends on nothing.
package lpgd_pkg;

    localparam int FACTOR_W   = 16;
    localparam int MODE_W     = 2;
    localparam int CFG_ADDR_W = 1;

    localparam logic [FACTOR_W-1:0] PERCENT_BASE = 16'd100;

    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } op_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_NONE    = 2'd0,
        MODE_FIXED   = 2'd1,
        MODE_DIVIDE  = 2'd2,
        MODE_PERCENT = 2'd3
    } mode_t;

    localparam logic [CFG_ADDR_W-1:0] REG_MODE   = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_FACTOR = 1'b1;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_DELTA = 6'b000010,
        ST_SETUP = 6'b000100,
        ST_SCALE = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_PUSH  = 6'b100000
    } front_state_t;

endpackage

>>> rtl/core/lpgd_div.sv
// Restoring divider for the skip period, one quotient bit per cycle.
// Depends on lpgd_pkg for the divisor width.
module lpgd_div #(
    parameter int N = 33
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [N-1:0]                  dividend,
    input  logic [lpgd_pkg::FACTOR_W-1:0] divisor,
    output logic                          done,
    output logic [N-1:0]                  quotient
);
    import lpgd_pkg::*;

    localparam int CNT_W = $clog2(N + 1);

    logic [N-1:0]        quo_reg;
    logic [FACTOR_W-1:0] rem_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                busy_reg;
    logic                done_reg;
    logic [FACTOR_W:0]   trial;
    logic                fits;

    assign trial = {rem_reg, quo_reg[N-1]};
    assign fits  = trial >= {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(N);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[N-2:0], fits};
            rem_reg <= fits ? FACTOR_W'(trial - {1'b0, divisor}) : trial[FACTOR_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> rtl/core/lpgd_queue.sv
// Small register queue between the command front end and the line walker.
// Generic in width and depth; depends on nothing.
module lpgd_queue #(
    parameter int WIDTH = 125,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = count_reg == CNT_W'(DEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

>>> rtl/core/lpgd_front.sv
// Command front end: takes input beats, sets up a line walk on start commands
// and forwards commands to the walker queue. Depends on lpgd_pkg and lpgd_div.
module lpgd_front #(
    parameter int COORD_BITS = 16,
    parameter int ENTRY_W    = 7 * COORD_BITS + 13
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic                          operation,
    input  logic signed [COORD_BITS-1:0]  x_start,
    input  logic signed [COORD_BITS-1:0]  y_start,
    input  logic signed [COORD_BITS-1:0]  x_end,
    input  logic signed [COORD_BITS-1:0]  y_end,
    input  logic [lpgd_pkg::MODE_W-1:0]   reduce_mode,
    input  logic [lpgd_pkg::FACTOR_W-1:0] reduce_factor,
    output logic                          q_push,
    output logic [ENTRY_W-1:0]            q_wdata,
    input  logic                          q_full
);
    import lpgd_pkg::*;

    localparam int CW = COORD_BITS;
    localparam int PW = CW + 1;
    localparam int IW = CW + 2;
    localparam int EW = CW + 3;
    localparam int NW = PW + FACTOR_W;
    localparam int QW = PW + 5;
    localparam int RW = PW + 6;

    localparam longint unsigned PCT_QUARTER = 64'(PERCENT_BASE) >> 2;
    localparam longint unsigned PCT_RECIP   =
        ((64'd1 << (PW + 10)) + PCT_QUARTER - 64'd1) / PCT_QUARTER;
    localparam longint unsigned PCT_LIMIT   = 64'(PERCENT_BASE) << PW;

    front_state_t state_reg;
    front_state_t state_next;

    logic signed [CW-1:0] x1_reg, y1_reg, x2_reg, y2_reg;
    logic [MODE_W-1:0]    mode_reg;
    logic [FACTOR_W-1:0]  factor_reg;
    logic [CW-1:0]        dx_reg, dy_reg;
    logic                 x_neg_reg, y_neg_reg, major_x_reg;
    logic [PW-1:0]        npix_reg;
    logic [EW-1:0]        err_reg;
    logic [IW-1:0]        inc_s_reg, inc_d_reg;
    logic [PW-1:0]        skip_reg;
    logic [NW-1:0]        prod_reg;

    logic signed [CW:0]   diff_x, diff_y;
    logic                 major_x;
    logic [CW-1:0]        dmaj, dmin;
    logic [CW:0]          dmin_minus_dmaj;
    logic [NW-1:0]        product;
    logic [QW-1:0]        pct_quarter;
    logic [QW+RW-1:0]     pct_scaled;
    logic [PW-1:0]        pct_skip;
    logic                 div_start;
    logic                 div_done;
    logic [PW-1:0]        div_quotient;
    logic                 accept;
    logic                 use_divider;

    function automatic logic [PW-1:0] sat_skip(input logic [NW-1:0] v);
        logic [NW-1:0] cap;
        cap = {{FACTOR_W{1'b0}}, {PW{1'b1}}};
        sat_skip = (v > cap) ? {PW{1'b1}} : v[PW-1:0];
    endfunction

    assign full   = (state_reg != ST_IDLE) || q_full;
    assign accept = push && !full;

    assign diff_x = {x2_reg[CW-1], x2_reg} - {x1_reg[CW-1], x1_reg};
    assign diff_y = {y2_reg[CW-1], y2_reg} - {y1_reg[CW-1], y1_reg};

    assign major_x         = dx_reg >= dy_reg;
    assign dmaj            = major_x ? dx_reg : dy_reg;
    assign dmin            = major_x ? dy_reg : dx_reg;
    assign dmin_minus_dmaj = {1'b0, dmin} - {1'b0, dmaj};

    assign product = {{FACTOR_W{1'b0}}, npix_reg} * {{PW{1'b0}}, factor_reg};

    // Percent mode divides by 100 as a quarter of the product times a rounded-up
    // reciprocal of 25, which is exact for every product below the saturation limit.
    assign pct_quarter = prod_reg[QW+1:2];
    assign pct_scaled  = {{RW{1'b0}}, pct_quarter} * {{QW{1'b0}}, RW'(PCT_RECIP)};
    assign pct_skip    = (prod_reg >= NW'(PCT_LIMIT)) ? {PW{1'b1}} : pct_scaled[PW+10 +: PW];

    assign use_divider = (mode_reg == MODE_DIVIDE) && (factor_reg != '0);
    assign div_start   = (state_reg == ST_SCALE) && use_divider;

    lpgd_div #(
        .N(PW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (npix_reg),
        .divisor  (factor_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb
    begin
        state_next = state_reg;
        q_push     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (op_t'(operation) == OP_STEP)
                    begin
                        q_push = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_DELTA;
                    end
                end
            end
            ST_DELTA: state_next = ST_SETUP;
            ST_SETUP: state_next = ST_SCALE;
            ST_SCALE:
            begin
                if (use_divider || (mode_reg == MODE_PERCENT))
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_DIV:
            begin
                if ((mode_reg == MODE_PERCENT) || div_done)
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (!q_full)
                begin
                    q_push     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && accept)
        begin
            x1_reg     <= x_start;
            y1_reg     <= y_start;
            x2_reg     <= x_end;
            y2_reg     <= y_end;
            mode_reg   <= reduce_mode;
            factor_reg <= reduce_factor;
        end
        if (state_reg == ST_DELTA)
        begin
            dx_reg    <= diff_x[CW] ? CW'(-diff_x) : diff_x[CW-1:0];
            dy_reg    <= diff_y[CW] ? CW'(-diff_y) : diff_y[CW-1:0];
            x_neg_reg <= diff_x[CW];
            y_neg_reg <= diff_y[CW];
        end
        if (state_reg == ST_SETUP)
        begin
            major_x_reg <= major_x;
            npix_reg    <= {1'b0, dmaj} + PW'(1);
            err_reg     <= {2'b00, dmin, 1'b0} - {3'b000, dmaj};
            inc_s_reg   <= {1'b0, dmin, 1'b0};
            inc_d_reg   <= {dmin_minus_dmaj, 1'b0};
        end
        if (state_reg == ST_SCALE)
        begin
            prod_reg <= product;
            if (mode_reg == MODE_FIXED)
            begin
                skip_reg <= sat_skip({{PW{1'b0}}, factor_reg});
            end
            else
            begin
                skip_reg <= '0;
            end
        end
        if (state_reg == ST_DIV)
        begin
            if (mode_reg == MODE_PERCENT)
            begin
                skip_reg <= pct_skip;
            end
            else if (div_done)
            begin
                skip_reg <= div_quotient;
            end
        end
    end

    always_comb
    begin
        if (state_reg == ST_PUSH)
        begin
            q_wdata = {OP_START, x1_reg, y1_reg, err_reg, inc_s_reg, inc_d_reg,
                       major_x_reg, x_neg_reg, y_neg_reg, npix_reg, skip_reg};
        end
        else
        begin
            q_wdata = {OP_STEP, {(ENTRY_W - 1){1'b0}}};
        end
    end

endmodule

>>> rtl/core/lpgd_back.sv
// Line walker: takes commands from the queue, steps the Bresenham walk and
// holds the result beat for the consumer. Depends on lpgd_pkg.
module lpgd_back #(
    parameter int COORD_BITS = 16,
    parameter int ENTRY_W    = 7 * COORD_BITS + 13
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [ENTRY_W-1:0]           q_rdata,
    input  logic                         q_empty,
    output logic                         q_pop,
    output logic                         empty,
    input  logic                         pop,
    output logic signed [COORD_BITS-1:0] pixel_x,
    output logic signed [COORD_BITS-1:0] pixel_y,
    output logic                         kept,
    output logic                         last
);
    import lpgd_pkg::*;

    localparam int CW = COORD_BITS;
    localparam int PW = CW + 1;
    localparam int IW = CW + 2;
    localparam int EW = CW + 3;

    logic          c_kind;
    logic [CW-1:0] c_x1, c_y1;
    logic [EW-1:0] c_err;
    logic [IW-1:0] c_inc_s, c_inc_d;
    logic          c_major, c_xneg, c_yneg;
    logic [PW-1:0] c_npix, c_skip;

    logic [CW-1:0] cur_x_reg, cur_y_reg;
    logic [EW-1:0] err_reg;
    logic [IW-1:0] inc_s_reg, inc_d_reg;
    logic          major_x_reg, x_neg_reg, y_neg_reg;
    logic [PW-1:0] left_reg, period_reg, count_reg;
    logic          active_reg;
    logic          out_valid_reg;
    logic [CW-1:0] out_x_reg, out_y_reg;
    logic          out_kept_reg, out_last_reg;

    logic          out_free;
    logic          is_step;
    logic          do_step;
    logic          keep;
    logic          fin;
    logic [CW-1:0] x_moved, y_moved;

    assign {c_kind, c_x1, c_y1, c_err, c_inc_s, c_inc_d, c_major, c_xneg, c_yneg,
            c_npix, c_skip} = q_rdata;

    assign out_free = !out_valid_reg || pop;
    assign is_step  = op_t'(c_kind) == OP_STEP;
    assign q_pop    = !q_empty && (!is_step || !active_reg || out_free);
    assign do_step  = q_pop && is_step && active_reg;
    assign keep     = count_reg == period_reg;
    assign fin      = left_reg <= PW'(1);
    assign x_moved  = cur_x_reg + (x_neg_reg ? {CW{1'b1}} : CW'(1));
    assign y_moved  = cur_y_reg + (y_neg_reg ? {CW{1'b1}} : CW'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            err_reg       <= '0;
            inc_s_reg     <= '0;
            inc_d_reg     <= '0;
            major_x_reg   <= 1'b0;
            x_neg_reg     <= 1'b0;
            y_neg_reg     <= 1'b0;
            left_reg      <= '0;
            period_reg    <= '0;
            count_reg     <= '0;
        end
        else
        begin
            if (do_step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end

            if (q_pop && !is_step)
            begin
                active_reg  <= 1'b1;
                cur_x_reg   <= c_x1;
                cur_y_reg   <= c_y1;
                err_reg     <= c_err;
                inc_s_reg   <= c_inc_s;
                inc_d_reg   <= c_inc_d;
                major_x_reg <= c_major;
                x_neg_reg   <= c_xneg;
                y_neg_reg   <= c_yneg;
                left_reg    <= c_npix;
                period_reg  <= c_skip;
                count_reg   <= c_skip;
            end
            else if (do_step)
            begin
                count_reg <= keep ? '0 : count_reg + PW'(1);
                if (fin)
                begin
                    left_reg   <= '0;
                    active_reg <= 1'b0;
                end
                else
                begin
                    left_reg <= left_reg - PW'(1);
                    if (err_reg[EW-1])
                    begin
                        err_reg <= err_reg + {inc_s_reg[IW-1], inc_s_reg};
                        if (major_x_reg)
                        begin
                            cur_x_reg <= x_moved;
                        end
                        else
                        begin
                            cur_y_reg <= y_moved;
                        end
                    end
                    else
                    begin
                        err_reg   <= err_reg + {inc_d_reg[IW-1], inc_d_reg};
                        cur_x_reg <= x_moved;
                        cur_y_reg <= y_moved;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_step)
        begin
            out_x_reg    <= cur_x_reg;
            out_y_reg    <= cur_y_reg;
            out_kept_reg <= keep;
            out_last_reg <= fin;
        end
    end

    assign empty   = !out_valid_reg;
    assign pixel_x = out_x_reg;
    assign pixel_y = out_y_reg;
    assign kept    = out_kept_reg;
    assign last    = out_last_reg;

endmodule

>>> rtl/core/line_point_generator_decimated.sv
// Decimated Bresenham line generator: a step beat's pixel is on the result ports in the
// cycle after the step is taken, and step beats are taken one per cycle while results are
// taken. A start beat holds the input through the delta, setup, scale and push states, and
// the div state in percent mode or in divide mode with a nonzero factor.
// Reset is asynchronous and active low: no line is active, mode is none, factor is 1.
// Depends on lpgd_pkg, lpgd_front, lpgd_queue and lpgd_back.
module line_point_generator_decimated #(
    parameter int COORD_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic                            operation,
    input  logic signed [COORD_BITS-1:0]    x_start,
    input  logic signed [COORD_BITS-1:0]    y_start,
    input  logic signed [COORD_BITS-1:0]    x_end,
    input  logic signed [COORD_BITS-1:0]    y_end,
    output logic                            empty,
    input  logic                            pop,
    output logic signed [COORD_BITS-1:0]    pixel_x,
    output logic signed [COORD_BITS-1:0]    pixel_y,
    output logic                            kept,
    output logic                            last,
    input  logic                            cfg_we,
    input  logic [lpgd_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [lpgd_pkg::FACTOR_W-1:0]   cfg_wdata
);
    import lpgd_pkg::*;

    localparam int ENTRY_W     = 7 * COORD_BITS + 13;
    localparam int QUEUE_DEPTH = 2;

    logic [MODE_W-1:0]   mode_reg;
    logic [FACTOR_W-1:0] factor_reg;
    logic                q_push;
    logic                q_full;
    logic                q_pop;
    logic                q_empty;
    logic [ENTRY_W-1:0]  q_wdata;
    logic [ENTRY_W-1:0]  q_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_NONE;
            factor_reg <= FACTOR_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_MODE:   mode_reg   <= cfg_wdata[MODE_W-1:0];
                REG_FACTOR: factor_reg <= cfg_wdata;
                default:    mode_reg   <= mode_reg;
            endcase
        end
    end

    lpgd_front #(
        .COORD_BITS (COORD_BITS),
        .ENTRY_W    (ENTRY_W)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .operation     (operation),
        .x_start       (x_start),
        .y_start       (y_start),
        .x_end         (x_end),
        .y_end         (y_end),
        .reduce_mode   (mode_reg),
        .reduce_factor (factor_reg),
        .q_push        (q_push),
        .q_wdata       (q_wdata),
        .q_full        (q_full)
    );

    lpgd_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    lpgd_back #(
        .COORD_BITS (COORD_BITS),
        .ENTRY_W    (ENTRY_W)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_rdata (q_rdata),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .pixel_x (pixel_x),
        .pixel_y (pixel_y),
        .kept    (kept),
        .last    (last)
    );

endmodule
